/* hw/rtl/spr_pkg.sv */
// Package for the shortest-path edge relaxer: field widths, codes, states and defaults.
`timescale 1ns / 1ps

package spr_pkg;

  // Fixed payload widths
  localparam int ACTION_W   = 2;
  localparam int NODE_W     = 10;
  localparam int WEIGHT_W   = 8;
  localparam int DIST_OUT_W = 16;

  // Configuration port
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 11;
  localparam int SRC_W       = 10;
  localparam int COUNT_W     = 11;

  localparam logic [COUNT_W-1:0] NODE_COUNT_RESET = 11'd1024;
  localparam logic [SRC_W-1:0]   SOURCE_RESET     = 10'd0;

  // Parameter defaults
  localparam int NODES_DEFAULT     = 1024;
  localparam int DIST_BITS_DEFAULT = 16;

  typedef enum logic [ACTION_W-1:0] {
    ACT_INIT   = 2'd0,
    ACT_RELAX  = 2'd1,
    ACT_READ   = 2'd2,
    ACT_UNUSED = 2'd3
  } action_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_SOURCE_NODE = 1'd0,
    CFG_NODE_COUNT  = 1'd1
  } cfg_index_t;

  typedef enum logic [2:0] {
    ST_WIPE,
    ST_IDLE,
    ST_EVAL,
    ST_CLEAR,
    ST_SOURCE
  } state_t;

endpackage

/* hw/rtl/spr_in_if.sv */
// Request channel interface: action and edge fields with valid/ready.
`timescale 1ns / 1ps

interface spr_in_if import spr_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  logic [NODE_W-1:0]   from_node;
  logic [NODE_W-1:0]   to_node;
  logic [WEIGHT_W-1:0] weight;

  modport source (output valid, action, from_node, to_node, weight, input ready);
  modport sink   (input valid, action, from_node, to_node, weight, output ready);
endinterface

/* hw/rtl/spr_out_if.sv */
// Result channel interface: distance and changed flag with valid/ready.
`timescale 1ns / 1ps

interface spr_out_if import spr_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [DIST_OUT_W-1:0] distance;
  logic                  changed;

  modport source (output valid, distance, changed, input ready);
  modport sink   (input valid, distance, changed, output ready);
endinterface

/* hw/rtl/shortest_path_edge_relaxer.sv */
// Shortest-path edge relaxer: distance memory with init, relax and read actions.
//
// One request is worked on at a time. Relax, read and the unused action code pass through
// the transfer cycle, which issues both memory reads (tail and head), and then the
// evaluation state on the registered read data, which compares, writes the head back
// when lowered and loads the result register. Init sweeps min(node_count, NODES)
// entries, one entry a cycle through the single write port, then the source entry is
// zeroed. After reset a clearing pass sets every entry to unreachable; no request is
// taken before it ends, configuration writes are taken as ever.
// A result waiting in the output register does not stop the next request transfer; the
// block only holds in its final cycle if the previous result has still not been taken.
// Distances are DIST_BITS wide, all ones meaning unreachable; the sum saturates there.
`timescale 1ns / 1ps

module shortest_path_edge_relaxer import spr_pkg::*; #(
  parameter int NODES     = NODES_DEFAULT,
  parameter int DIST_BITS = DIST_BITS_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  spr_in_if.sink                 request,
  spr_out_if.source              result
);

  localparam int IDX_W = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int CNT_W = $clog2(NODES + 1);
  localparam logic [DIST_BITS-1:0] UNREACH  = '1;
  localparam logic [CNT_W-1:0]     LAST_IDX = CNT_W'(NODES - 1);

  // Configuration registers
  logic [SRC_W-1:0]   source_node;
  logic [COUNT_W-1:0] node_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      source_node <= SOURCE_RESET;
      node_count  <= NODE_COUNT_RESET;
    end else if (cfg_we) begin
      case (cfg_index_t'(cfg_index))
        CFG_SOURCE_NODE: source_node <= cfg_data[SRC_W-1:0];
        CFG_NODE_COUNT:  node_count  <= cfg_data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Control
  state_t state, state_next;
  logic   accept;
  logic   slot_free;
  logic   from_in, to_in;
  logic [CNT_W-1:0] init_len;

  // Item registers
  action_t             act;
  logic [WEIGHT_W-1:0] item_weight;
  logic [IDX_W-1:0]    to_addr;
  logic                from_ok, to_ok;
  logic [CNT_W-1:0]    clr_idx;
  logic [CNT_W-1:0]    clr_end;

  // Distance memory
  logic [DIST_BITS-1:0] mem [NODES];
  logic [DIST_BITS-1:0] rd_from, rd_to;
  logic                 mem_we;
  logic [IDX_W-1:0]     mem_waddr;
  logic [DIST_BITS-1:0] mem_wdata;

  // Relax datapath
  logic [DIST_BITS:0]   sum;
  logic [DIST_BITS-1:0] cand;
  logic                 lower;

  // Result register
  logic                  res_load;
  logic [DIST_OUT_W-1:0] res_distance;
  logic                  res_changed;

  assign accept    = request.valid && request.ready;
  assign slot_free = !result.valid || result.ready;
  assign from_in   = 32'(request.from_node) < NODES;
  assign to_in     = 32'(request.to_node) < NODES;
  assign init_len  = (32'(node_count) > NODES) ? CNT_W'(NODES) : CNT_W'(node_count);

  assign sum   = {1'b0, rd_from} + (DIST_BITS + 1)'(item_weight);
  assign cand  = (sum >= {1'b0, UNREACH}) ? UNREACH : sum[DIST_BITS-1:0];
  assign lower = rd_to > cand;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  // Both reads issue at the request transfer; the write of the previous item has landed
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_from <= mem[IDX_W'(request.from_node)];
      rd_to   <= mem[IDX_W'(request.to_node)];
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      act         <= action_t'(request.action);
      item_weight <= request.weight;
      to_addr     <= IDX_W'(request.to_node);
      from_ok     <= from_in;
      to_ok       <= to_in;
    end
  end

  // Sweep counter: shared by the reset pass and the init sweep
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_idx <= '0;
      clr_end <= CNT_W'(NODES);
    end else if (accept) begin
      clr_idx <= '0;
      clr_end <= init_len;
    end else if (state == ST_WIPE || state == ST_CLEAR) begin
      clr_idx <= clr_idx + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_WIPE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_WIPE: begin
        if (clr_idx == LAST_IDX) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          if (action_t'(request.action) == ACT_INIT) begin
            state_next = (init_len == '0) ? ST_SOURCE : ST_CLEAR;
          end else begin
            state_next = ST_EVAL;
          end
        end
      end
      ST_CLEAR: begin
        if (clr_idx == clr_end - CNT_W'(1)) state_next = ST_SOURCE;
      end
      ST_EVAL, ST_SOURCE: begin
        if (slot_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    request.ready = 1'b0;
    mem_we        = 1'b0;
    mem_waddr     = clr_idx[IDX_W-1:0];
    mem_wdata     = UNREACH;
    res_load      = 1'b0;
    res_distance  = '0;
    res_changed   = 1'b0;
    case (state)
      ST_IDLE: begin
        request.ready = 1'b1;
      end
      ST_WIPE, ST_CLEAR: begin
        mem_we = 1'b1;
      end
      ST_EVAL: begin
        if (slot_free) begin
          res_load = 1'b1;
          case (act)
            ACT_RELAX: begin
              if (from_ok && to_ok) begin
                mem_we       = lower;
                mem_waddr    = to_addr;
                mem_wdata    = cand;
                res_changed  = lower;
                res_distance = DIST_OUT_W'(lower ? cand : rd_to);
              end else begin
                res_distance = DIST_OUT_W'(UNREACH);
              end
            end
            ACT_READ: begin
              res_distance = DIST_OUT_W'(from_ok ? rd_from : UNREACH);
            end
            default: ;
          endcase
        end
      end
      ST_SOURCE: begin
        if (slot_free) begin
          res_load  = 1'b1;
          mem_we    = 32'(source_node) < NODES;
          mem_waddr = IDX_W'(source_node);
          mem_wdata = '0;
        end
      end
      default: ;
    endcase
  end

  // Output register: frees the request side while a result waits
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (res_load) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      result.distance <= res_distance;
      result.changed  <= res_changed;
    end
  end

  // Checks
  a_idle_no_write: assert property (@(posedge clk) disable iff (rst)
    state == ST_IDLE |-> !mem_we)
    else $error("memory written while idle");

  a_relax_lowers: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EVAL && mem_we) |-> (mem_wdata < rd_to && mem_waddr == to_addr))
    else $error("relax write does not lower the head entry");

  a_sweep_bound: assert property (@(posedge clk) disable iff (rst)
    state == ST_CLEAR |-> clr_idx < clr_end)
    else $error("init sweep past node count");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EVAL && !slot_free) |=> state == ST_EVAL)
    else $error("evaluation left while result slot full");

  a_result_origin: assert property (@(posedge clk) disable iff (rst)
    $rose(result.valid) |-> ($past(state) == ST_EVAL || $past(state) == ST_SOURCE))
    else $error("result loaded outside a final cycle");

endmodule
